/* rtl/tljt_pkg.sv */
// ----------------------------------------------------------------------------
// tljt_pkg
// Types, constants and helpers for the two-link leg Jacobian torque block.
// ----------------------------------------------------------------------------
package tljt_pkg;

    localparam int unsigned DIV_STAGES = 48;
    localparam int unsigned LAST_STAGE = DIV_STAGES + 4;

    localparam logic [7:0] CFG_UPPER_LINK = 8'd0;
    localparam logic [7:0] CFG_LOWER_LINK = 8'd1;

    localparam logic [15:0] UPPER_LINK_RESET = 16'd13763;
    localparam logic [15:0] LOWER_LINK_RESET = 16'd16384;

    localparam logic [16:0] SIN_C1 = 17'd102944;
    localparam logic [15:0] SIN_C3 = 16'd42048;
    localparam logic [12:0] SIN_C5 = 13'd4640;
    localparam logic [15:0] QUARTER_TURN = 16'd16384;

    localparam logic signed [31:0] SAT_MAX = 32'sh7FFFFFFF;
    localparam logic signed [31:0] SAT_MIN = 32'sh80000000;

    typedef struct packed {
        logic               side;
        logic        [15:0] t1;
        logic        [15:0] t2;
        logic        [15:0] leg;
        logic signed [31:0] torque;
        logic        [15:0] len;
        logic signed [31:0] fl;
        logic signed [31:0] fx;
        logic signed [31:0] fy;
    } in_t;

    typedef struct packed {
        logic               side;
        logic        [15:0] t1;
        logic        [15:0] t12;
        logic        [15:0] leg;
        logic        [15:0] len;
        logic signed [31:0] fl;
        logic signed [31:0] fx;
        logic signed [31:0] fy;
        logic               fault;
        logic               tpos;
        logic               tneg;
    } sd_t;

    // round to nearest (ties up), drop 16 fraction bits, saturate to 32 bits
    function automatic logic signed [31:0] round_sat(input logic signed [52:0] a,
                                                     input logic signed [52:0] b);
        logic signed [54:0] w;
        logic signed [54:0] sh;
        w  = 55'(a) + 55'(b) + 55'sd32768;
        sh = w >>> 16;
        if (sh > 55'(SAT_MAX)) begin
            return SAT_MAX;
        end else if (sh < 55'(SAT_MIN)) begin
            return SAT_MIN;
        end
        return sh[31:0];
    endfunction

endpackage

/* rtl/two_link_leg_jacobian_torque.sv */
// ----------------------------------------------------------------------------
// two_link_leg_jacobian_torque
// Joint torques of a two-link leg from polar and Cartesian leg forces.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel takes one leg sample per item: angles, leg torque, leg length,
//   axial force and a Cartesian force pair; tuser carries the leg side.
//   m_* channel returns one item per sample: four Q16.16 joint torques in
//   tdata, leg side and the zero-length fault flag in tuser.
//   cfg_* writes the link length registers (index 0 upper, 1 lower); it is
//   always ready and is meant to be written while no item is in flight.
// Pipeline:
//   an input register, a 48-stage restoring divider (one quotient bit per stage)
//   for leg torque over leg length, a quotient register, then multiply, round,
//   multiply and the output register.
//   Sines run beside the divider's last stages; the Jacobian beside the first multiply.
//   One item is accepted per cycle while the output is not stalled.
// Reset and stall:
//   aresetn (synchronous, low) empties the pipeline and restores the link
//   lengths. When m_tready is low with a result held, the whole pipeline
//   freezes and s_tready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module two_link_leg_jacobian_torque (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // hip_angle, knee_angle, virtual_leg_angle, virtual_leg_torque,
    // virtual_leg_length, axial_force, cartesian_force_x, cartesian_force_y
    input  logic [191:0] s_tdata,
    // leg_side
    input  logic [0:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // polar_joint1_torque, polar_joint2_torque, cartesian_joint1_torque,
    // cartesian_joint2_torque
    output logic [127:0] m_tdata,
    // side_out, length_fault
    output logic [1:0]   m_tuser,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [7:0]   cfg_addr,
    input  logic [15:0]  cfg_wdata
);

    logic        en;
    logic [15:0] upper_link_reg;
    logic [15:0] lower_link_reg;

    tljt_pkg::in_t ir_reg;
    tljt_pkg::sd_t sd_next;
    tljt_pkg::sd_t dly_reg [1:tljt_pkg::LAST_STAGE];
    logic          v_reg   [0:tljt_pkg::LAST_STAGE];

    logic [31:0] tmag;

    logic [15:0] rem_reg [1:tljt_pkg::DIV_STAGES];
    logic [47:0] dq_reg  [1:tljt_pkg::DIV_STAGES];

    logic [15:0] ang [0:5];
    logic [16:0] za_reg  [0:5];
    logic        na_reg  [0:5];
    logic [16:0] zb_reg  [0:5];
    logic [16:0] z2b_reg [0:5];
    logic        nb_reg  [0:5];
    logic [16:0] zc_reg  [0:5];
    logic [16:0] z2c_reg [0:5];
    logic [15:0] t3c_reg [0:5];
    logic        nc_reg  [0:5];
    logic [16:0] zd_reg  [0:5];
    logic [16:0] t4d_reg [0:5];
    logic        nd_reg  [0:5];
    logic signed [17:0] s_reg [0:5];

    logic [47:0]        qmag;
    logic signed [31:0] q_next;
    logic signed [31:0] q_reg;

    logic signed [49:0] pa_reg, pb_reg, pc_reg, pd_reg;
    logic signed [34:0] ja_reg, jb_reg, jc_reg, jd_reg;
    logic signed [16:0] l1s, l2s;

    logic signed [50:0] p0s, p1s;
    logic signed [35:0] j00s, j01s, j10s, j11s;
    logic signed [33:0] p0_reg, p1_reg;
    logic signed [18:0] j00_reg, j01_reg, j10_reg, j11_reg;

    logic signed [52:0] m0_reg, m1_reg, m2_reg, m3_reg;
    logic signed [52:0] m4_reg, m5_reg, m6_reg, m7_reg;

    logic               m_tvalid_reg;
    logic signed [31:0] pol1_reg, pol2_reg, car1_reg, car2_reg;
    logic               side_reg, fault_reg;

    assign en        = !m_tvalid_reg || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {car2_reg, car1_reg, pol2_reg, pol1_reg};
    assign m_tuser   = {fault_reg, side_reg};

    // link length registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upper_link_reg <= tljt_pkg::UPPER_LINK_RESET;
            lower_link_reg <= tljt_pkg::LOWER_LINK_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_addr)
                tljt_pkg::CFG_UPPER_LINK: upper_link_reg <= cfg_wdata;
                tljt_pkg::CFG_LOWER_LINK: lower_link_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i <= tljt_pkg::LAST_STAGE; i++) begin
                v_reg[i] <= 1'b0;
            end
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            v_reg[0] <= s_tvalid;
            for (int i = 1; i <= tljt_pkg::LAST_STAGE; i++) begin
                v_reg[i] <= v_reg[i-1];
            end
            m_tvalid_reg <= v_reg[tljt_pkg::LAST_STAGE];
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (en) begin
            ir_reg.side   <= s_tuser[0];
            ir_reg.t1     <= s_tdata[15:0];
            ir_reg.t2     <= s_tdata[31:16];
            ir_reg.leg    <= s_tdata[47:32];
            ir_reg.torque <= s_tdata[79:48];
            ir_reg.len    <= s_tdata[95:80];
            ir_reg.fl     <= s_tdata[127:96];
            ir_reg.fx     <= s_tdata[159:128];
            ir_reg.fy     <= s_tdata[191:160];
        end
    end

    always_comb begin
        sd_next.side  = ir_reg.side;
        sd_next.t1    = ir_reg.t1;
        sd_next.t12   = ir_reg.t1 + ir_reg.t2;
        sd_next.leg   = ir_reg.leg;
        sd_next.len   = ir_reg.len;
        sd_next.fl    = ir_reg.fl;
        sd_next.fx    = ir_reg.fx;
        sd_next.fy    = ir_reg.fy;
        sd_next.fault = (ir_reg.len == 16'd0);
        sd_next.tpos  = (ir_reg.torque > 32'sd0);
        sd_next.tneg  = ir_reg.torque[31];
        tmag = ir_reg.torque[31] ? (32'd0 - ir_reg.torque) : ir_reg.torque;
    end

    // sideband delay line
    always_ff @(posedge aclk) begin
        if (en) begin
            dly_reg[1] <= sd_next;
            for (int i = 2; i <= tljt_pkg::LAST_STAGE; i++) begin
                dly_reg[i] <= dly_reg[i-1];
            end
        end
    end

    // restoring divider, one quotient bit per stage
    for (genvar k = 1; k <= tljt_pkg::DIV_STAGES; k++) begin : g_div
        logic [15:0] rin;
        logic [47:0] dqin;
        logic [15:0] d;
        logic [16:0] r2;
        logic        ge;
        logic [16:0] rn;
        if (k == 1) begin : g_first
            assign rin  = 16'd0;
            assign dqin = {tmag, 16'd0};
            assign d    = ir_reg.len;
        end else begin : g_rest
            assign rin  = rem_reg[k-1];
            assign dqin = dq_reg[k-1];
            assign d    = dly_reg[k-1].len;
        end
        assign r2 = {rin, dqin[47]};
        assign ge = (r2 >= {1'b0, d});
        assign rn = ge ? (r2 - {1'b0, d}) : r2;
        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k] <= rn[15:0];
                dq_reg[k]  <= {dqin[46:0], ge};
            end
        end
    end

    // sine lanes: s1, c1, s12, c12, sin(phi), cos(phi)
    always_comb begin
        ang[0] = dly_reg[tljt_pkg::DIV_STAGES - 4].t1;
        ang[1] = dly_reg[tljt_pkg::DIV_STAGES - 4].t1 + tljt_pkg::QUARTER_TURN;
        ang[2] = dly_reg[tljt_pkg::DIV_STAGES - 4].t12;
        ang[3] = dly_reg[tljt_pkg::DIV_STAGES - 4].t12 + tljt_pkg::QUARTER_TURN;
        ang[4] = dly_reg[tljt_pkg::DIV_STAGES - 4].leg - tljt_pkg::QUARTER_TURN;
        ang[5] = dly_reg[tljt_pkg::DIV_STAGES - 4].leg;
    end

    for (genvar i = 0; i < 6; i++) begin : g_sin
        logic [14:0] rr;
        logic [33:0] zz;
        logic [29:0] c5z;
        logic [32:0] u;
        logic [33:0] w;
        assign rr  = ang[i][14] ? (15'd16384 - {1'b0, ang[i][13:0]}) : {1'b0, ang[i][13:0]};
        assign zz  = 34'(za_reg[i]) * 34'(za_reg[i]);
        assign c5z = 30'(tljt_pkg::SIN_C5) * 30'(z2b_reg[i]);
        assign u   = 33'(t3c_reg[i]) * 33'(z2c_reg[i]);
        assign w   = 34'(t4d_reg[i]) * 34'(zd_reg[i]);
        always_ff @(posedge aclk) begin
            if (en) begin
                za_reg[i]  <= {rr, 2'b00};
                na_reg[i]  <= ang[i][15];
                zb_reg[i]  <= za_reg[i];
                z2b_reg[i] <= 17'(zz[32:16]);
                nb_reg[i]  <= na_reg[i];
                zc_reg[i]  <= zb_reg[i];
                z2c_reg[i] <= z2b_reg[i];
                t3c_reg[i] <= tljt_pkg::SIN_C3 - {2'b00, c5z[29:16]};
                nc_reg[i]  <= nb_reg[i];
                zd_reg[i]  <= zc_reg[i];
                t4d_reg[i] <= tljt_pkg::SIN_C1 - u[32:16];
                nd_reg[i]  <= nc_reg[i];
                s_reg[i]   <= nd_reg[i] ? -$signed({1'b0, w[32:16]})
                                        : $signed({1'b0, w[32:16]});
            end
        end
    end

    // quotient sign and saturation
    always_comb begin
        qmag = dq_reg[tljt_pkg::DIV_STAGES];
        if (dly_reg[tljt_pkg::DIV_STAGES].fault) begin
            if (dly_reg[tljt_pkg::DIV_STAGES].tpos) begin
                q_next = tljt_pkg::SAT_MAX;
            end else if (dly_reg[tljt_pkg::DIV_STAGES].tneg) begin
                q_next = tljt_pkg::SAT_MIN;
            end else begin
                q_next = 32'sd0;
            end
        end else if (dly_reg[tljt_pkg::DIV_STAGES].tneg) begin
            if (qmag > 48'h0000_8000_0000) begin
                q_next = tljt_pkg::SAT_MIN;
            end else begin
                q_next = 32'(48'd0 - qmag);
            end
        end else if (qmag > 48'h0000_7FFF_FFFF) begin
            q_next = tljt_pkg::SAT_MAX;
        end else begin
            q_next = qmag[31:0];
        end
    end

    assign l1s = $signed({1'b0, upper_link_reg});
    assign l2s = $signed({1'b0, lower_link_reg});

    assign p0s  = -51'(pa_reg) - 51'(pb_reg) + 51'sd32768;
    assign p1s  = -51'(pc_reg) + 51'(pd_reg) + 51'sd32768;
    assign j00s = -36'(ja_reg) - 36'(jb_reg) + 36'sd32768;
    assign j01s = -36'(jb_reg) + 36'sd32768;
    assign j10s = 36'(jc_reg) + 36'(jd_reg) + 36'sd32768;
    assign j11s = 36'(jd_reg) + 36'sd32768;

    always_ff @(posedge aclk) begin
        if (en) begin
            q_reg <= q_next;
            // polar force and Jacobian products
            pa_reg <= 50'(s_reg[5]) * 50'(q_reg);
            pb_reg <= 50'(s_reg[4]) * 50'(dly_reg[tljt_pkg::DIV_STAGES + 1].fl);
            pc_reg <= 50'(s_reg[4]) * 50'(q_reg);
            pd_reg <= 50'(s_reg[5]) * 50'(dly_reg[tljt_pkg::DIV_STAGES + 1].fl);
            ja_reg <= 35'(l1s) * 35'(s_reg[0]);
            jb_reg <= 35'(l2s) * 35'(s_reg[2]);
            jc_reg <= 35'(l1s) * 35'(s_reg[1]);
            jd_reg <= 35'(l2s) * 35'(s_reg[3]);
            // rounding
            p0_reg  <= p0s[49:16];
            p1_reg  <= p1s[49:16];
            j00_reg <= j00s[34:16];
            j01_reg <= j01s[34:16];
            j10_reg <= j10s[34:16];
            j11_reg <= j11s[34:16];
            // transposed Jacobian products
            m0_reg <= 53'(j00_reg) * 53'(p0_reg);
            m1_reg <= 53'(j10_reg) * 53'(p1_reg);
            m2_reg <= 53'(j01_reg) * 53'(p0_reg);
            m3_reg <= 53'(j11_reg) * 53'(p1_reg);
            m4_reg <= 53'(j00_reg) * 53'(dly_reg[tljt_pkg::DIV_STAGES + 3].fx);
            m5_reg <= 53'(j10_reg) * 53'(dly_reg[tljt_pkg::DIV_STAGES + 3].fy);
            m6_reg <= 53'(j01_reg) * 53'(dly_reg[tljt_pkg::DIV_STAGES + 3].fx);
            m7_reg <= 53'(j11_reg) * 53'(dly_reg[tljt_pkg::DIV_STAGES + 3].fy);
            // output register
            pol1_reg  <= tljt_pkg::round_sat(m0_reg, m1_reg);
            pol2_reg  <= tljt_pkg::round_sat(m2_reg, m3_reg);
            car1_reg  <= tljt_pkg::round_sat(m4_reg, m5_reg);
            car2_reg  <= tljt_pkg::round_sat(m6_reg, m7_reg);
            side_reg  <= dly_reg[tljt_pkg::LAST_STAGE].side;
            fault_reg <= dly_reg[tljt_pkg::LAST_STAGE].fault;
        end
    end

endmodule

/* dv/two_link_leg_jacobian_torque_tb.sv */
// ----------------------------------------------------------------------------
// two_link_leg_jacobian_torque_tb
// Leg samples go in and joint torques come out. Each sample is predicted
// bit for bit in the testbench and checked against the block's result.
// Idling on both sides is random except in the last phase, which runs
// without idling; the link lengths are changed between phases.
// ----------------------------------------------------------------------------
module two_link_leg_jacobian_torque_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic        side;
        logic [15:0] hip;
        logic [15:0] knee;
        logic [15:0] leg_ang;
        logic [31:0] leg_torque;
        logic [15:0] leg_len;
        logic [31:0] axial;
        logic [31:0] fx;
        logic [31:0] fy;
    } sample_t;

    typedef struct {
        logic        side;
        logic [31:0] tq[4];
        logic        fault;
    } torques_t;

    class torque_scoreboard;
        torques_t    pending[$];
        int          errors;
        logic [15:0] upper_len;
        logic [15:0] lower_len;

        function new();
            errors    = 0;
            upper_len = tljt_pkg::UPPER_LINK_RESET;
            lower_len = tljt_pkg::LOWER_LINK_RESET;
        endfunction

        function longint rnd(longint v);
            rnd = (v + 32768) >>> 16;
        endfunction

        function longint clip(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        function longint sine(logic [15:0] a);
            logic [1:0]  quad;
            logic [13:0] r14;
            longint      r, z, z2, t;
            quad = a[15:14];
            r14  = a[13:0];
            r    = quad[0] ? 16384 - r14 : r14;
            z    = r << 2;
            z2   = (z * z) >> 16;
            t    = (4640 * z2) >> 16;
            t    = 42048 - t;
            t    = (t * z2) >> 16;
            t    = 102944 - t;
            t    = (t * z) >> 16;
            return quad[1] ? -t : t;
        endfunction

        function longint cosine(logic [15:0] a);
            cosine = sine(a + tljt_pkg::QUARTER_TURN);
        endfunction

        function void note_sample(sample_t s);
            torques_t    e;
            longint      l1, l2, s1, c1, s12, c12, j00, j01, j10, j11;
            longint      tq, ln, fl, fx, fy, q, sp, cp, p0, p1;
            logic [15:0] t12, phi;
            l1  = upper_len;
            l2  = lower_len;
            t12 = s.hip + s.knee;
            s1  = sine(s.hip);
            c1  = cosine(s.hip);
            s12 = sine(t12);
            c12 = cosine(t12);
            j00 = rnd(-(l1 * s1) - l2 * s12);
            j01 = rnd(-(l2 * s12));
            j10 = rnd(l1 * c1 + l2 * c12);
            j11 = rnd(l2 * c12);
            tq  = $signed(s.leg_torque);
            ln  = s.leg_len;
            fl  = $signed(s.axial);
            fx  = $signed(s.fx);
            fy  = $signed(s.fy);
            e.fault = (ln == 0);
            if (ln == 0) q = tq > 0 ? 64'sd2147483647 : (tq < 0 ? -64'sd2147483648 : 0);
            else q = clip((tq * 65536) / ln);
            phi = s.leg_ang - tljt_pkg::QUARTER_TURN;
            sp  = sine(phi);
            cp  = cosine(phi);
            p0  = rnd(-(cp * q) - sp * fl);
            p1  = rnd(-(sp * q) + cp * fl);
            e.side  = s.side;
            e.tq[0] = 32'(clip(rnd(j00 * p0 + j10 * p1)));
            e.tq[1] = 32'(clip(rnd(j01 * p0 + j11 * p1)));
            e.tq[2] = 32'(clip(rnd(j00 * fx + j10 * fy)));
            e.tq[3] = 32'(clip(rnd(j01 * fx + j11 * fy)));
            pending.push_back(e);
        endfunction

        function void check_result(logic [127:0] data, logic [1:0] user);
            torques_t e;
            if (pending.size() == 0) begin
                $error("unexpected result %h", data);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (user[0] !== e.side) begin
                $error("side_out exp %0d got %0d", e.side, user[0]);
                errors++;
            end
            if (user[1] !== e.fault) begin
                $error("length_fault exp %0d got %0d", e.fault, user[1]);
                errors++;
            end
            for (int k = 0; k < 4; k++) begin
                if (data[32*k +: 32] !== e.tq[k]) begin
                    $error("%s exp %h got %h",
                           k == 0 ? "polar_joint1_torque" : k == 1 ? "polar_joint2_torque" :
                           k == 2 ? "cartesian_joint1_torque" : "cartesian_joint2_torque",
                           e.tq[k], data[32*k +: 32]);
                    errors++;
                end
            end
        endfunction
    endclass

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [191:0] s_tdata;
    logic [0:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [127:0] m_tdata;
    logic [1:0]   m_tuser;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [7:0]   cfg_addr;
    logic [15:0]  cfg_wdata;

    torque_scoreboard board;
    int  send_idle_pct;
    int  recv_idle_pct;
    int  idle_cycles;
    int  n_sent;
    int  n_faults;

    two_link_leg_jacobian_torque i_dut (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            board.check_result(m_tdata, m_tuser);
        end
        if (aresetn) begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic send_sample(sample_t s);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= s.side;
        s_tdata  <= {s.fy, s.fx, s.axial, s.leg_len, s.leg_torque,
                     s.leg_ang, s.knee, s.hip};
        do @(posedge aclk); while (!s_tready);
        board.note_sample(s);
        if (s.leg_len == 0) n_faults++;
        n_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    task automatic write_reg(logic [7:0] idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == tljt_pkg::CFG_UPPER_LINK) board.upper_len = val;
        else if (idx == tljt_pkg::CFG_LOWER_LINK) board.lower_len = val;
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_force();
        case ($urandom_range(5))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return $urandom_range(131072) - 65536;
            default: return $urandom;
        endcase
    endfunction

    function automatic sample_t rand_sample();
        sample_t s;
        s.side       = 1'($urandom_range(1));
        s.hip        = 16'($urandom);
        s.knee       = 16'($urandom);
        s.leg_ang    = 16'($urandom);
        s.leg_torque = rand_force();
        s.leg_len    = ($urandom_range(19) == 0) ? 16'd0 :
                       ($urandom_range(3) == 0) ? 16'($urandom_range(3) + 1) : 16'($urandom);
        s.axial      = rand_force();
        s.fx         = rand_force();
        s.fy         = rand_force();
        return s;
    endfunction

    task automatic run_random(int count);
        repeat (count) send_sample(rand_sample());
    endtask

    initial begin
        sample_t s;
        board         = new();
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = '0;
        m_tready      = 1'b0;
        cfg_valid     = 1'b0;
        cfg_addr      = '0;
        cfg_wdata     = '0;
        send_idle_pct = 23;
        recv_idle_pct = 46;
        idle_cycles   = 0;
        n_sent        = 0;
        n_faults      = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: extremes, zero length with each torque sign, quadrant angles
        for (int k = 0; k < 20; k++) begin
            s = rand_sample();
            s.side       = k[0];
            s.hip        = 16'((k % 4) * 16384 + (k >= 8 ? 16'h7FFF : 16'h0));
            s.knee       = k[1] ? 16'h8000 : 16'h7FFF;
            s.leg_ang    = k[2] ? 16'hFFFF : 16'h0000;
            s.leg_torque = k % 3 == 0 ? 32'h7FFFFFFF : k % 3 == 1 ? 32'h80000000 : 32'h0;
            s.leg_len    = k < 6 ? 16'd0 : k[0] ? 16'hFFFF : 16'd1;
            s.axial      = k[1] ? 32'h7FFFFFFF : 32'h80000000;
            s.fx         = k[2] ? 32'h80000000 : 32'h7FFFFFFF;
            s.fy         = k[3] ? 32'h80000000 : 32'hFFFFFFFF;
            send_sample(s);
        end
        drain();

        write_reg(tljt_pkg::CFG_UPPER_LINK, 16'hFFFF);
        write_reg(tljt_pkg::CFG_LOWER_LINK, 16'hFFFF);
        send_idle_pct = 23;
        recv_idle_pct = 46;
        run_random(260);
        drain();

        write_reg(tljt_pkg::CFG_UPPER_LINK, 16'd1);
        write_reg(tljt_pkg::CFG_LOWER_LINK, 16'd1);
        send_idle_pct = 46;
        recv_idle_pct = 23;
        run_random(260);
        drain();

        write_reg(tljt_pkg::CFG_UPPER_LINK, 16'($urandom_range(65535, 1)));
        write_reg(tljt_pkg::CFG_LOWER_LINK, 16'($urandom_range(65535, 1)));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(260);
        drain();

        $display("run covered %0d samples, %0d with zero leg length, four link settings",
                 n_sent, n_faults);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
